// ===== rtl/shcm_pkg.sv =====
package shcm_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned ChW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned ScanLen  = (CHANNELS < MaskW) ? CHANNELS : MaskW;
  localparam int unsigned StepW    = 3;

  typedef logic [ChW-1:0]   chan_idx_t;
  typedef logic [StepW-1:0] step_t;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_INVALID = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_REQUIRED = 2'd0,
    CFG_MAX_AGE  = 2'd1,
    CFG_BATTERY  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_INPUT,
    COND_SCAN_MORE,
    COND_OUT_BUSY
  } cond_e;

  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_UPDATE = 3'd1;
  localparam step_t ST_CHAN   = 3'd2;
  localparam step_t ST_SCAN   = 3'd3;
  localparam step_t ST_EMIT   = 3'd4;
  localparam step_t ST_RETURN = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         channel;
    logic signed [31:0] sample;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic [31:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic               in_range;
    logic               channel_ready;
    logic               all_ready;
    logic               required_valid;
    logic               battery_valid;
    logic [31:0]        run_of_invalid;
    logic [31:0]        good_count;
    logic [31:0]        bad_count;
    logic signed [31:0] recent_value;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic chan;
    logic scan;
    logic emit;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic out_busy;
  } seq_cond_t;

  function automatic uword_t urom(input step_t step);
    uword_t w;
    w = '{ctl: '0, cond: COND_ALWAYS, target: ST_IDLE};
    unique case (step)
      ST_IDLE: begin
        w.ctl.accept = 1'b1;
        w.cond       = COND_NO_INPUT;
        w.target     = ST_IDLE;
      end
      ST_UPDATE: begin
        w.ctl.update = 1'b1;
        w.cond       = COND_NEVER;
      end
      ST_CHAN: begin
        w.ctl.chan = 1'b1;
        w.cond     = COND_NEVER;
      end
      ST_SCAN: begin
        w.ctl.scan = 1'b1;
        w.cond     = COND_SCAN_MORE;
        w.target   = ST_SCAN;
      end
      ST_EMIT: begin
        w.ctl.emit = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target   = ST_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == '1) ? x : x + 32'd1;
  endfunction

endpackage

// ===== rtl/shcm_useq.sv =====
module shcm_useq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  shcm_pkg::seq_cond_t   cond_i,
  output shcm_pkg::ctl_t        ctl_o
);

  shcm_pkg::step_t  step_q, step_d;
  shcm_pkg::uword_t word;
  logic             jump;

  always_comb begin
    word = shcm_pkg::urom(step_q);
    unique case (word.cond)
      shcm_pkg::COND_ALWAYS:    jump = 1'b1;
      shcm_pkg::COND_NEVER:     jump = 1'b0;
      shcm_pkg::COND_NO_INPUT:  jump = ~cond_i.in_valid;
      shcm_pkg::COND_SCAN_MORE: jump = ~cond_i.scan_last;
      shcm_pkg::COND_OUT_BUSY:  jump = cond_i.out_busy;
      default:                  jump = 1'b1;
    endcase
    step_d = jump ? word.target : step_q + shcm_pkg::step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= shcm_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o = word.ctl;

endmodule

// ===== rtl/shcm_dp.sv =====
module shcm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shcm_pkg::ctl_t      ctl_i,
  input  logic                take_i,
  input  shcm_pkg::in_item_t  item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                scan_last_o,
  output shcm_pkg::out_item_t result_o
);

  localparam int unsigned N = shcm_pkg::CHANNELS;

  logic [shcm_pkg::MaskW-1:0] required_q;
  logic [31:0]                max_age_q;
  logic [2:0]                 battery_q;

  shcm_pkg::in_item_t item_q;

  logic [N-1:0] valid_q;
  logic [N-1:0] ever_q;
  logic [31:0]  time_q    [N];
  logic [31:0]  value_q   [N];
  logic [31:0]  good_q    [N];
  logic [31:0]  bad_q     [N];
  logic [31:0]  run_q     [N];

  shcm_pkg::chan_idx_t ch, sel, scan_q;
  logic        ch_ok, lim_ok, hit, fresh;
  logic [31:0] age, sel_time;
  logic        hit_q, chan_ready_q, req_ready_q, req_valid_q;
  logic [N-1:0] req_mask;
  logic        bat_valid;

  assign ch    = item_q.channel[shcm_pkg::ChW-1:0];
  assign ch_ok = 5'(item_q.channel) < 5'(N);
  assign lim_ok = item_q.lower_limit <= item_q.upper_limit;
  assign hit   = item_q.sample >= item_q.lower_limit && item_q.sample <= item_q.upper_limit;

  assign sel      = ctl_i.scan ? scan_q : ch;
  assign sel_time = time_q[sel];
  assign age      = item_q.now_time - sel_time;
  assign fresh    = (sel_time != 32'd0) && (age <= max_age_q);

  assign scan_last_o = scan_q == shcm_pkg::chan_idx_t'(shcm_pkg::ScanLen - 1);

  always_comb begin
    bat_valid = 1'b0;
    for (int i = 0; i < N; i++) begin
      req_mask[i] = (i < shcm_pkg::MaskW) ? required_q[i % shcm_pkg::MaskW] : 1'b0;
      if (i < shcm_pkg::MaskW && battery_q == 3'(i)) begin
        bat_valid = valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      required_q <= 8'd1;
      max_age_q  <= 32'd1000;
      battery_q  <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        shcm_pkg::CFG_REQUIRED: required_q <= cfg_data_i[shcm_pkg::MaskW-1:0];
        shcm_pkg::CFG_MAX_AGE:  max_age_q  <= cfg_data_i;
        shcm_pkg::CFG_BATTERY:  battery_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      ever_q       <= '0;
      hit_q        <= 1'b0;
      chan_ready_q <= 1'b0;
      req_ready_q  <= 1'b1;
      req_valid_q  <= 1'b1;
      scan_q       <= '0;
      for (int i = 0; i < N; i++) begin
        time_q[i]  <= '0;
        value_q[i] <= '0;
        good_q[i]  <= '0;
        bad_q[i]   <= '0;
        run_q[i]   <= '0;
      end
    end else begin
      if (ctl_i.update) begin
        hit_q <= ch_ok && item_q.op == shcm_pkg::OP_SAMPLE && lim_ok && hit;
        if (ch_ok) begin
          if (item_q.op == shcm_pkg::OP_SAMPLE && lim_ok) begin
            value_q[ch] <= item_q.sample;
            time_q[ch]  <= item_q.now_time;
            if (hit) begin
              valid_q[ch] <= 1'b1;
              ever_q[ch]  <= 1'b1;
              good_q[ch]  <= shcm_pkg::sat_inc(good_q[ch]);
              run_q[ch]   <= '0;
            end else begin
              valid_q[ch] <= 1'b0;
              bad_q[ch]   <= shcm_pkg::sat_inc(bad_q[ch]);
              run_q[ch]   <= shcm_pkg::sat_inc(run_q[ch]);
            end
          end else if (item_q.op == shcm_pkg::OP_SAMPLE ||
                       item_q.op == shcm_pkg::OP_INVALID) begin
            valid_q[ch] <= 1'b0;
            time_q[ch]  <= item_q.now_time;
            bad_q[ch]   <= shcm_pkg::sat_inc(bad_q[ch]);
            run_q[ch]   <= shcm_pkg::sat_inc(run_q[ch]);
          end
        end
      end
      if (ctl_i.chan) begin
        chan_ready_q <= ch_ok && valid_q[ch] && ever_q[ch] && fresh;
        req_ready_q  <= 1'b1;
        req_valid_q  <= 1'b1;
        scan_q       <= '0;
      end
      if (ctl_i.scan) begin
        if (req_mask[scan_q]) begin
          if (!(valid_q[scan_q] && ever_q[scan_q])) begin
            req_valid_q <= 1'b0;
            req_ready_q <= 1'b0;
          end else if (!fresh) begin
            req_ready_q <= 1'b0;
          end
        end
        scan_q <= scan_last_o ? '0 : scan_q + shcm_pkg::chan_idx_t'(1);
      end
    end
  end

  always_comb begin
    result_o.in_range       = hit_q;
    result_o.channel_ready  = chan_ready_q;
    result_o.all_ready      = req_ready_q;
    result_o.required_valid = req_valid_q;
    result_o.battery_valid  = bat_valid;
    result_o.run_of_invalid = ch_ok ? run_q[ch]   : 32'd0;
    result_o.good_count     = ch_ok ? good_q[ch]  : 32'd0;
    result_o.bad_count      = ch_ok ? bad_q[ch]   : 32'd0;
    result_o.recent_value   = ch_ok ? value_q[ch] : 32'sd0;
  end

endmodule

// ===== rtl/sensor_channel_health_monitor.sv =====
// Sensor channel health monitor: per-channel health records for eight channels.
// Input channel: in_valid_i / in_stall_o carry one beat per item (op, channel,
// sample, limits, now_time). Output channel: out_valid_o / out_stall_i carry one
// result beat per item. A beat moves at a clock edge with valid high and stall low.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 required channel mask, 1 max age in ms, 2 battery channel); write while idle.
// A microprogram steps through accept, update, addressed-channel check, an
// eight-step readiness scan through one age comparator, and result load.
// The result is loaded into the output register at the result load step, and a new
// item is taken only at the accept step, once the program has returned there.
// The result sits in an output register, so the next item is taken and worked
// on while the previous result waits; a stalled result holds, and the program
// waits at the load step only while a finished result is still not taken.
// Reset (rst_ni low, asynchronous) clears all channel records, counters and the
// in-range and channel-ready flags, empties the output register, sets the all-ready
// and required-valid flags, mask to channel 0, max age 1000, battery channel 0.
module sensor_channel_health_monitor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  shcm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shcm_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  shcm_pkg::ctl_t      ctl;
  shcm_pkg::seq_cond_t cond;
  shcm_pkg::out_item_t result;
  shcm_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                scan_last;
  logic                take;
  logic                out_busy;
  logic                load;

  assign in_stall_o = ~ctl.accept;
  assign take       = in_valid_i & ctl.accept;
  assign out_busy   = out_valid_q & out_stall_i;
  assign load       = ctl.emit & ~out_busy;

  assign cond = '{in_valid: in_valid_i, scan_last: scan_last, out_busy: out_busy};

  shcm_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctl_o  (ctl)
  );

  shcm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .take_i      (take),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .scan_last_o (scan_last),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== bench/tb.sv =====
module tb;

  localparam logic [1:0]         OP_UNDEFINED = 2'd3;
  localparam logic signed [31:0] S_MIN        = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX        = 32'sh7FFF_FFFF;
  localparam int                 HOLD_CYCLES  = 400;
  localparam int                 DRAIN_CYCLES = 16;
  localparam int                 STUCK_LIMIT  = 3000;

  typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_PERIODIC} pace_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  shcm_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  shcm_pkg::out_item_t out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [1:0]          cfg_index_i = '0;
  logic [31:0]         cfg_data_i  = '0;

  sensor_channel_health_monitor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Health records and settings as the block should hold them
  logic        ch_valid [shcm_pkg::CHANNELS];
  logic        ch_ever  [shcm_pkg::CHANNELS];
  logic [31:0] ch_stamp [shcm_pkg::CHANNELS];
  logic [31:0] ch_value [shcm_pkg::CHANNELS];
  logic [31:0] ch_good  [shcm_pkg::CHANNELS];
  logic [31:0] ch_bad   [shcm_pkg::CHANNELS];
  logic [31:0] ch_run   [shcm_pkg::CHANNELS];
  logic [7:0]  need_mask;
  logic [31:0] age_limit;
  logic [2:0]  batt_ch;

  shcm_pkg::out_item_t expected_reports [$];
  int          mismatches    = 0;
  int          reports_seen  = 0;
  int          stuck_cycles  = 0;
  int          burst_left    = 0;
  logic        steady_sender = 1'b0;
  logic [31:0] clock_ms      = 32'd100;
  int          hold_asked    = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          pace_left     = 0;
  int          pace_period   = 2;
  int          pace_count    = 0;
  pace_e       pace          = PACE_FREE;

  function automatic logic [31:0] bump(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic logic is_fresh(input int ch, input logic [31:0] now);
    logic [31:0] age;
    age = now - ch_stamp[ch];
    return (ch_stamp[ch] != 32'd0) && (age <= age_limit);
  endfunction

  function automatic shcm_pkg::out_item_t update_health(input shcm_pkg::in_item_t it);
    shcm_pkg::out_item_t r;
    logic signed [31:0]  smp, lo, hi;
    logic [2:0]          ch;
    logic                ch_ok, hit, ok;
    smp   = it.sample;
    lo    = it.lower_limit;
    hi    = it.upper_limit;
    ch    = it.channel[2:0];
    ch_ok = (it.channel < shcm_pkg::CHANNELS);
    hit   = 1'b0;
    r     = '0;
    if (ch_ok) begin
      if (it.op == shcm_pkg::OP_SAMPLE && lo <= hi) begin
        hit          = (smp >= lo) && (smp <= hi);
        ch_value[ch] = smp;
        ch_stamp[ch] = it.now_time;
        if (hit) begin
          ch_valid[ch] = 1'b1;
          ch_ever[ch]  = 1'b1;
          ch_good[ch]  = bump(ch_good[ch]);
          ch_run[ch]   = '0;
        end else begin
          ch_valid[ch] = 1'b0;
          ch_bad[ch]   = bump(ch_bad[ch]);
          ch_run[ch]   = bump(ch_run[ch]);
        end
      end else if (it.op == shcm_pkg::OP_SAMPLE || it.op == shcm_pkg::OP_INVALID) begin
        ch_valid[ch] = 1'b0;
        ch_stamp[ch] = it.now_time;
        ch_bad[ch]   = bump(ch_bad[ch]);
        ch_run[ch]   = bump(ch_run[ch]);
      end
    end
    r.all_ready      = 1'b1;
    r.required_valid = 1'b1;
    for (int i = 0; i < shcm_pkg::CHANNELS && i < 8; i++) begin
      if (need_mask[i]) begin
        ok = ch_valid[i] && ch_ever[i];
        if (!ok) r.required_valid = 1'b0;
        if (!ok || !is_fresh(i, it.now_time)) r.all_ready = 1'b0;
      end
    end
    r.in_range      = hit;
    r.channel_ready = ch_ok && ch_valid[ch] && ch_ever[ch] && is_fresh(ch, it.now_time);
    r.battery_valid = (batt_ch < shcm_pkg::CHANNELS) && ch_valid[batt_ch];
    if (ch_ok) begin
      r.run_of_invalid = ch_run[ch];
      r.good_count     = ch_good[ch];
      r.bad_count      = ch_bad[ch];
      r.recent_value   = ch_value[ch];
    end
    return r;
  endfunction

  task automatic reset_records();
    need_mask = 8'd1;
    age_limit = 32'd1000;
    batt_ch   = 3'd0;
    for (int i = 0; i < shcm_pkg::CHANNELS; i++) begin
      ch_valid[i] = 1'b0;
      ch_ever[i]  = 1'b0;
      ch_stamp[i] = '0;
      ch_value[i] = '0;
      ch_good[i]  = '0;
      ch_bad[i]   = '0;
      ch_run[i]   = '0;
    end
  endtask

  function automatic logic signed [31:0] pick_between(input logic signed [31:0] lo, hi);
    longint          span;
    longint unsigned r;
    span = longint'(hi) - longint'(lo) + 1;
    r    = {$urandom(), $urandom()};
    return 32'(longint'(lo) + (r % span));
  endfunction

  function automatic shcm_pkg::in_item_t make_item(input logic [1:0] op,
                                                   input logic [3:0] ch,
                                                   input logic want_in,
                                                   input logic [31:0] now);
    shcm_pkg::in_item_t it;
    logic signed [31:0] a, b, t, s;
    int                 shape;
    shape = $urandom_range(0, 19);
    a     = $urandom();
    b     = $urandom();
    if (shape < 3) begin
      a = S_MIN;
      b = S_MAX;
    end else if (shape < 8) begin
      a = 32'($urandom_range(0, 400)) - 32'sd200;
      b = a + 32'($urandom_range(0, 300));
    end else if (shape == 10) begin
      b = a;
    end
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (shape == 8 || shape == 9) begin
      if (a == b) b = (b == S_MAX) ? b - 1 : b + 1;
      t = a;
      a = (a > b) ? a : b;
      b = (t > b) ? b : t;
      s = $urandom();
    end else if (want_in) begin
      case ($urandom_range(0, 9))
        0:       s = a;
        1:       s = b;
        default: s = pick_between(a, b);
      endcase
    end else if (a != S_MIN && (b == S_MAX || $urandom_range(0, 1) == 0)) begin
      s = ($urandom_range(0, 3) == 0) ? a - 1 : pick_between(S_MIN, a - 1);
    end else if (b != S_MAX) begin
      s = ($urandom_range(0, 3) == 0) ? b + 1 : pick_between(b + 1, S_MAX);
    end else begin
      s = $urandom();
    end
    it.op          = op;
    it.channel     = ch;
    it.sample      = s;
    it.lower_limit = a;
    it.upper_limit = b;
    it.now_time    = now;
    return it;
  endfunction

  function automatic shcm_pkg::in_item_t mk(input logic [1:0] op, input logic [3:0] ch,
                                            input logic signed [31:0] smp, lo, hi,
                                            input logic [31:0] now);
    shcm_pkg::in_item_t it;
    it.op          = op;
    it.channel     = ch;
    it.sample      = smp;
    it.lower_limit = lo;
    it.upper_limit = hi;
    it.now_time    = now;
    return it;
  endfunction

  task automatic send_item(input shcm_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_reports.push_back(update_health(it));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input shcm_pkg::cfg_idx_e idx, input logic [31:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      shcm_pkg::CFG_REQUIRED: need_mask = data[7:0];
      shcm_pkg::CFG_MAX_AGE:  age_limit = data;
      shcm_pkg::CFG_BATTERY:  batt_ch   = data[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] mask, input logic [31:0] age,
                                input logic [2:0] batt);
    write_reg(shcm_pkg::CFG_REQUIRED, ($urandom() & 32'hFFFF_FF00) | mask);
    write_reg(shcm_pkg::CFG_MAX_AGE, age);
    write_reg(shcm_pkg::CFG_BATTERY, ($urandom() & 32'hFFFF_FFF8) | batt);
  endtask

  task automatic advance_clock();
    int          k;
    logic [31:0] lim;
    k = $urandom_range(0, 99);
    if (k < 2) begin
      clock_ms = $urandom();
    end else if (k < 3) begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5);
    end else if (k < 4) begin
      clock_ms = '0;
    end else begin
      lim = age_limit >> 2;
      if (lim > 32'd5000) lim = 32'd5000;
      clock_ms += $urandom_range(0, lim + 1);
    end
  endtask

  task automatic run_traffic(input int count);
    int         n, k;
    logic [1:0] op;
    logic [3:0] ch;
    n = 0;
    while (n < count) begin
      k  = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
      if (k < 4) begin
        for (int c = 0; c < shcm_pkg::CHANNELS; c++) begin
          advance_clock();
          send_item(make_item(shcm_pkg::OP_SAMPLE, 4'(c), 1'b1, clock_ms));
        end
        n += shcm_pkg::CHANNELS;
      end else if (k < 7) begin
        send_item(make_item(shcm_pkg::OP_QUERY, ch, 1'b1,
                            clock_ms - $urandom_range(1, 50)));
        n++;
      end else begin
        advance_clock();
        if (k < 65) op = shcm_pkg::OP_SAMPLE;
        else if (k < 77) op = shcm_pkg::OP_INVALID;
        else if (k < 96) op = shcm_pkg::OP_QUERY;
        else op = OP_UNDEFINED;
        send_item(make_item(op, ch, $urandom_range(0, 99) < 85, clock_ms));
        n++;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_item(mk(shcm_pkg::OP_QUERY,   4'd0,  32'sd0, 32'sd0, 32'sd0, 32'd5));
    send_item(mk(shcm_pkg::OP_QUERY,   4'd7,  32'sd0, 32'sd0, 32'sd0, 32'd6));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd0,  32'sd0, -32'sd1, 32'sd1, 32'd10));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd0,  S_MIN, S_MIN, S_MAX, 32'd20));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd0,  S_MAX, S_MIN, S_MAX, 32'd30));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd1,  32'sd99, 32'sd100, 32'sd200, 32'd31));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd1,  32'sd201, 32'sd100, 32'sd200, 32'd32));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd2,  32'sd0, 32'sd5, -32'sd5, 32'd33));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd2,  32'sd7, 32'sd7, 32'sd7, 32'd34));
    send_item(mk(shcm_pkg::OP_INVALID, 4'd2,  S_MAX, S_MIN, S_MAX, 32'd40));
    send_item(mk(shcm_pkg::OP_QUERY,   4'd2,  32'sd1, 32'sd0, 32'sd2, 32'd50));
    send_item(mk(OP_UNDEFINED,         4'd2,  32'sd1, 32'sd0, 32'sd2, 32'd60));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd3,  32'sd1, 32'sd0, 32'sd2, 32'd0));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd8,  32'sd1, 32'sd0, 32'sd2, 32'd61));
    send_item(mk(shcm_pkg::OP_INVALID, 4'd15, 32'sd1, 32'sd0, 32'sd2, 32'd62));
    send_item(mk(shcm_pkg::OP_QUERY,   4'd12, S_MIN, S_MAX, S_MIN, 32'd63));
    send_item(mk(shcm_pkg::OP_QUERY,   4'd0,  32'sd0, 32'sd0, 32'sd0, 32'd1030));
    send_item(mk(shcm_pkg::OP_QUERY,   4'd0,  32'sd0, 32'sd0, 32'sd0, 32'd1031));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd4,  -32'sd3, -32'sd9, 32'sd0, 32'hFFFF_FFFF));
    send_item(mk(shcm_pkg::OP_QUERY,   4'd4,  32'sd0, 32'sd0, 32'sd0, 32'd999));
    send_item(mk(shcm_pkg::OP_QUERY,   4'd4,  32'sd0, 32'sd0, 32'sd0, 32'd1000));
    send_item(mk(shcm_pkg::OP_SAMPLE,  4'd0,  32'sd5, 32'sd0, 32'sd9, 32'd2000));
  endtask

  task automatic test_register_sweep();
    apply_settings(8'hFF, 32'd0, 3'd7);
    run_traffic(240);
    apply_settings(8'h00, 32'hFFFF_FFFF, 3'd3);
    run_traffic(240);
    apply_settings(8'hA5, 32'd20, 3'd5);
    run_traffic(240);
    apply_settings(8'h5A, 32'd1, 3'd1);
    run_traffic(240);
    apply_settings(8'hFF, 32'd400, 3'd2);
    run_traffic(240);
    apply_settings(8'h0F, 32'd1000, 3'd6);
    run_traffic(240);
  endtask

  task automatic test_output_holdoff();
    steady_sender = 1'b1;
    hold_asked++;
    repeat (16) begin
      advance_clock();
      send_item(make_item(shcm_pkg::OP_SAMPLE, 4'($urandom_range(0, 7)), 1'b1, clock_ms));
    end
    steady_sender = 1'b0;
  endtask

  task automatic test_random_traffic();
    repeat (2) begin
      apply_settings(8'($urandom()), $urandom_range(0, 3000), 3'($urandom()));
      run_traffic(180);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d field %s: expected %h, got %h", reports_seen, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin : receiver_pace
    logic stall;
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (pace_left == 0) begin
      pace        = pace_e'($urandom_range(0, 3));
      pace_left   = $urandom_range(50, 300);
      pace_period = $urandom_range(2, 9);
    end
    pace_left--;
    pace_count++;
    if (hold_left > 0) begin
      hold_left--;
      stall = 1'b1;
    end else begin
      case (pace)
        PACE_FREE:  stall = 1'b0;
        PACE_LIGHT: stall = ($urandom_range(0, 3) == 0);
        PACE_HEAVY: stall = ($urandom_range(0, 9) < 7);
        default:    stall = (pace_count % pace_period) < (pace_period >> 1);
      endcase
    end
    out_stall_i <= stall;
  end

  always @(posedge clk_i) begin : check_reports
    shcm_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d arrived with nothing pending: %h", reports_seen, out_item_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("in_range",       want.in_range,       out_item_o.in_range);
        check_field("channel_ready",  want.channel_ready,  out_item_o.channel_ready);
        check_field("all_ready",      want.all_ready,      out_item_o.all_ready);
        check_field("required_valid", want.required_valid, out_item_o.required_valid);
        check_field("battery_valid",  want.battery_valid,  out_item_o.battery_valid);
        check_field("run_of_invalid", want.run_of_invalid, out_item_o.run_of_invalid);
        check_field("good_count",     want.good_count,     out_item_o.good_count);
        check_field("bad_count",      want.bad_count,      out_item_o.bad_count);
        check_field("recent_value",   want.recent_value,   out_item_o.recent_value);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("sensor_channel_health_monitor: mismatch");
      $finish;
    end
  end

  initial begin
    reset_records();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_register_sweep();
    test_output_holdoff();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("sensor_channel_health_monitor: match");
    end else begin
      $display("sensor_channel_health_monitor: mismatch");
    end
    $finish;
  end

endmodule
